// File: rtl/sha1sh_pkg.sv
// Shared types, constants and helper functions of the SHA-1 stream hasher.
package sha1sh_pkg;

   // Block geometry and round count
   localparam int unsigned BLOCK_BITS  = 512;
   localparam int unsigned WORD_BITS   = 32;
   localparam int unsigned NUM_ROUNDS  = 80;
   localparam int unsigned NUM_CHAIN   = 5;
   localparam int unsigned FILL_BITS   = 6;
   localparam int unsigned COUNT_BITS  = 61;
   localparam int unsigned ROUND_BITS  = 7;
   localparam int unsigned WIDX_BITS   = 3;

   localparam logic [FILL_BITS-1:0]  FILL_PAD_END  = 6'd55;   // last byte before length field
   localparam logic [FILL_BITS-1:0]  FILL_BLK_END  = 6'd63;   // last byte of a block
   localparam logic [ROUND_BITS-1:0] ROUND_LAST    = 7'd79;
   localparam logic [WIDX_BITS-1:0]  WIDX_LAST     = 3'd4;
   localparam logic [7:0]            PAD_BYTE      = 8'h80;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_ONE,
      ST_PAD_ZERO,
      ST_LEN,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } state_type;

   // Source of the byte shifted into the block
   typedef enum logic [1:0] {
      BSEL_INPUT,
      BSEL_PAD,
      BSEL_ZERO,
      BSEL_LEN
   } byte_sel_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic                  push;
      byte_sel_type          bsel;
      logic                  count_inc;
      logic                  load_vars;
      logic                  round_en;
      logic [ROUND_BITS-1:0] round_idx;
      logic                  chain_add;
      logic [WIDX_BITS-1:0]  word_idx;
      logic                  clear;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic fill_pad_end;
      logic fill_blk_end;
   } status_type;

   // Initial chaining value for word idx
   function automatic logic [WORD_BITS-1:0] chain_init(input logic [WIDX_BITS-1:0] idx);
      logic [WORD_BITS-1:0] val;
      case (idx)
         3'd0:    val = 32'h67452301;
         3'd1:    val = 32'hefcdab89;
         3'd2:    val = 32'h98badcfe;
         3'd3:    val = 32'h10325476;
         3'd4:    val = 32'hc3d2e1f0;
         default: val = '0;
      endcase
      return val;
   endfunction

   // Round constant for round t
   function automatic logic [WORD_BITS-1:0] round_k(input logic [ROUND_BITS-1:0] t);
      logic [WORD_BITS-1:0] val;
      if (t < 7'd20)      val = 32'h5a827999;
      else if (t < 7'd40) val = 32'h6ed9eba1;
      else if (t < 7'd60) val = 32'h8f1bbcdc;
      else                val = 32'hca62c1d6;
      return val;
   endfunction

   // Round function for round t
   function automatic logic [WORD_BITS-1:0] round_f(input logic [ROUND_BITS-1:0] t,
                                                    input logic [WORD_BITS-1:0] b,
                                                    input logic [WORD_BITS-1:0] c,
                                                    input logic [WORD_BITS-1:0] d);
      logic [WORD_BITS-1:0] val;
      if (t < 7'd20)      val = (b & c) | (~b & d);
      else if (t < 7'd40) val = b ^ c ^ d;
      else if (t < 7'd60) val = (b & c) | (b & d) | (c & d);
      else                val = b ^ c ^ d;
      return val;
   endfunction

endpackage

// File: rtl/sha1sh_ctrl.sv
// Controller state machine: byte loading, padding, rounds and digest output.
module sha1sh_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    in_has_byte,
   input  logic                    in_end,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic                    rsp_tlast,
   input  sha1sh_pkg::status_type  status,
   output sha1sh_pkg::cmd_type     cmd
);

   sha1sh_pkg::state_type state_ff, state_in;
   sha1sh_pkg::state_type ret_ff, ret_in;
   logic [sha1sh_pkg::ROUND_BITS-1:0] round_ff, round_in;
   logic [sha1sh_pkg::WIDX_BITS-1:0]  word_ff, word_in;
   logic req_acc;
   logic rsp_acc;

   assign req_acc = req_tvalid && (state_ff == sha1sh_pkg::ST_IDLE);
   assign rsp_acc = rsp_tready && (state_ff == sha1sh_pkg::ST_EMIT);

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha1sh_pkg::ST_IDLE;
         ret_ff   <= sha1sh_pkg::ST_IDLE;
         round_ff <= '0;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         round_ff <= round_in;
         word_ff  <= word_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         sha1sh_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (in_has_byte && status.fill_blk_end) begin
                  state_in = sha1sh_pkg::ST_ROUND;
                  ret_in   = in_end ? sha1sh_pkg::ST_PAD_ONE : sha1sh_pkg::ST_IDLE;
               end else if (in_end) begin
                  state_in = sha1sh_pkg::ST_PAD_ONE;
               end
            end
         end
         sha1sh_pkg::ST_PAD_ONE: begin
            if (status.fill_blk_end) begin
               state_in = sha1sh_pkg::ST_ROUND;
               ret_in   = sha1sh_pkg::ST_PAD_ZERO;
            end else if (status.fill_pad_end) begin
               state_in = sha1sh_pkg::ST_LEN;
            end else begin
               state_in = sha1sh_pkg::ST_PAD_ZERO;
            end
         end
         sha1sh_pkg::ST_PAD_ZERO: begin
            if (status.fill_blk_end) begin
               state_in = sha1sh_pkg::ST_ROUND;
               ret_in   = sha1sh_pkg::ST_PAD_ZERO;
            end else if (status.fill_pad_end) begin
               state_in = sha1sh_pkg::ST_LEN;
            end
         end
         sha1sh_pkg::ST_LEN: begin
            if (status.fill_blk_end) begin
               state_in = sha1sh_pkg::ST_ROUND;
               ret_in   = sha1sh_pkg::ST_EMIT;
            end
         end
         sha1sh_pkg::ST_ROUND: begin
            if (round_ff == sha1sh_pkg::ROUND_LAST) state_in = sha1sh_pkg::ST_ADD;
         end
         sha1sh_pkg::ST_ADD: begin
            state_in = ret_ff;
         end
         sha1sh_pkg::ST_EMIT: begin
            if (rsp_acc && word_ff == sha1sh_pkg::WIDX_LAST) state_in = sha1sh_pkg::ST_IDLE;
         end
         default: begin
            state_in = sha1sh_pkg::ST_IDLE;
         end
      endcase
   end

   // Round and digest word counters
   always_comb begin
      round_in = '0;
      word_in  = word_ff;
      if (state_ff == sha1sh_pkg::ST_ROUND) round_in = round_ff + 1'b1;
      if (rsp_acc) begin
         word_in = (word_ff == sha1sh_pkg::WIDX_LAST) ? '0 : word_ff + 1'b1;
      end
   end

   // Outputs
   always_comb begin
      cmd           = '0;
      cmd.bsel      = sha1sh_pkg::BSEL_INPUT;
      cmd.round_idx = round_ff;
      cmd.word_idx  = word_ff;
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      case (state_ff)
         sha1sh_pkg::ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.push      = req_acc && in_has_byte;
            cmd.count_inc = req_acc && in_has_byte;
            cmd.load_vars = req_acc && in_has_byte && status.fill_blk_end;
         end
         sha1sh_pkg::ST_PAD_ONE: begin
            cmd.push      = 1'b1;
            cmd.bsel      = sha1sh_pkg::BSEL_PAD;
            cmd.load_vars = status.fill_blk_end;
         end
         sha1sh_pkg::ST_PAD_ZERO: begin
            cmd.push      = 1'b1;
            cmd.bsel      = sha1sh_pkg::BSEL_ZERO;
            cmd.load_vars = status.fill_blk_end;
         end
         sha1sh_pkg::ST_LEN: begin
            cmd.push      = 1'b1;
            cmd.bsel      = sha1sh_pkg::BSEL_LEN;
            cmd.load_vars = status.fill_blk_end;
         end
         sha1sh_pkg::ST_ROUND: begin
            cmd.round_en = 1'b1;
         end
         sha1sh_pkg::ST_ADD: begin
            cmd.chain_add = 1'b1;
         end
         sha1sh_pkg::ST_EMIT: begin
            rsp_tvalid = 1'b1;
            cmd.clear  = rsp_acc && (word_ff == sha1sh_pkg::WIDX_LAST);
         end
         default: begin
            cmd.push = 1'b0;
         end
      endcase
   end

   assign rsp_tlast = (word_ff == sha1sh_pkg::WIDX_LAST);

endmodule

// File: rtl/sha1sh_dp.sv
// Datapath: block/schedule window, byte count, round variables and chaining words.
module sha1sh_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [7:0]                           in_byte,
   input  sha1sh_pkg::cmd_type                  cmd,
   output sha1sh_pkg::status_type               status,
   output logic [sha1sh_pkg::WORD_BITS-1:0]     digest_word
);

   localparam int unsigned WB = sha1sh_pkg::WORD_BITS;
   localparam int unsigned BB = sha1sh_pkg::BLOCK_BITS;

   // Window holds the 16 schedule words, word 0 (current round) in the top bits
   logic [BB-1:0] window_ff, window_in;
   logic [sha1sh_pkg::FILL_BITS-1:0]  fill_ff, fill_in;
   logic [sha1sh_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [WB-1:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [WB-1:0] a_in, b_in, c_in, d_in, e_in;
   logic [WB-1:0] chain_ff [sha1sh_pkg::NUM_CHAIN];
   logic [WB-1:0] chain_in [sha1sh_pkg::NUM_CHAIN];

   logic [7:0]    push_byte;
   logic [63:0]   len_shift;
   logic [WB-1:0] w0, w2, w8, w13, w_mix, w_new;
   logic [WB-1:0] temp;

   // Byte source select; length bytes go out big-endian by fill position
   always_comb begin
      len_shift = {count_ff, 3'b000} >> {~fill_ff[2:0], 3'b000};
      case (cmd.bsel)
         sha1sh_pkg::BSEL_INPUT: push_byte = in_byte;
         sha1sh_pkg::BSEL_PAD:   push_byte = sha1sh_pkg::PAD_BYTE;
         sha1sh_pkg::BSEL_ZERO:  push_byte = 8'h00;
         sha1sh_pkg::BSEL_LEN:   push_byte = len_shift[7:0];
         default:                push_byte = 8'h00;
      endcase
   end

   // Message schedule taps
   assign w0    = window_ff[BB-1        -: WB];
   assign w2    = window_ff[BB-1-2*WB   -: WB];
   assign w8    = window_ff[BB-1-8*WB   -: WB];
   assign w13   = window_ff[BB-1-13*WB  -: WB];
   assign w_mix = w13 ^ w8 ^ w2 ^ w0;
   assign w_new = {w_mix[WB-2:0], w_mix[WB-1]};

   // One SHA-1 round
   assign temp = {a_ff[WB-6:0], a_ff[WB-1:WB-5]}
               + sha1sh_pkg::round_f(cmd.round_idx, b_ff, c_ff, d_ff)
               + e_ff + w0 + sha1sh_pkg::round_k(cmd.round_idx);

   // Window, fill and count next values
   always_comb begin
      window_in = window_ff;
      fill_in   = fill_ff;
      count_in  = count_ff;
      if (cmd.push) begin
         window_in = {window_ff[BB-9:0], push_byte};
         fill_in   = fill_ff + 1'b1;
      end else if (cmd.round_en) begin
         window_in = {window_ff[BB-WB-1:0], w_new};
      end
      if (cmd.count_inc) count_in = count_ff + 1'b1;
      if (cmd.clear) begin
         fill_in  = '0;
         count_in = '0;
      end
   end

   // Working variables
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (cmd.load_vars) begin
         a_in = chain_ff[0];
         b_in = chain_ff[1];
         c_in = chain_ff[2];
         d_in = chain_ff[3];
         e_in = chain_ff[4];
      end else if (cmd.round_en) begin
         a_in = temp;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[WB-1:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   // Chaining words
   always_comb begin
      for (int i = 0; i < sha1sh_pkg::NUM_CHAIN; i++) begin
         chain_in[i] = chain_ff[i];
         if (cmd.clear) begin
            chain_in[i] = sha1sh_pkg::chain_init(sha1sh_pkg::WIDX_BITS'(i));
         end
      end
      if (cmd.chain_add) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end
   end

   // Control-side state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         count_ff <= '0;
         for (int i = 0; i < sha1sh_pkg::NUM_CHAIN; i++) begin
            chain_ff[i] <= sha1sh_pkg::chain_init(sha1sh_pkg::WIDX_BITS'(i));
         end
      end else begin
         fill_ff  <= fill_in;
         count_ff <= count_in;
         for (int i = 0; i < sha1sh_pkg::NUM_CHAIN; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      window_ff <= window_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      d_ff      <= d_in;
      e_ff      <= e_in;
   end

   // Status and digest word select
   assign status.fill_pad_end = (fill_ff == sha1sh_pkg::FILL_PAD_END);
   assign status.fill_blk_end = (fill_ff == sha1sh_pkg::FILL_BLK_END);

   always_comb begin
      case (cmd.word_idx)
         3'd0:    digest_word = chain_ff[0];
         3'd1:    digest_word = chain_ff[1];
         3'd2:    digest_word = chain_ff[2];
         3'd3:    digest_word = chain_ff[3];
         3'd4:    digest_word = chain_ff[4];
         default: digest_word = '0;
      endcase
   end

endmodule

// File: rtl/sha1_stream_hasher_core.sv
// SHA-1 stream hasher top level: controller plus datapath.
// Input: a byte item is taken while idle; every 64th byte starts a compression of 80
//   rounds at one round per cycle and one chaining add, during which no input is taken.
// End of message: padding and length go in at one byte per cycle, except during the one
//   or two compressions they cause; then five digest words go out, one per cycle when ready.
// Reset (synchronous, active high) restores the initial chaining values and clears counts.
module sha1_stream_hasher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tuser,    // [0] has_byte
   input  logic        req_tlast,    // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [31:0] digest_word
   output logic [2:0]  rsp_tuser,    // [2:0] word_index
   output logic        rsp_tlast     // last_word
);

   sha1sh_pkg::cmd_type    cmd;
   sha1sh_pkg::status_type status;

   sha1sh_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .in_has_byte (req_tuser),
      .in_end      (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tlast   (rsp_tlast),
      .status      (status),
      .cmd         (cmd)
   );

   sha1sh_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .in_byte     (req_tdata),
      .cmd         (cmd),
      .status      (status),
      .digest_word (rsp_tdata)
   );

   assign rsp_tuser = cmd.word_idx;

endmodule

// File: rtl/sha1sh_checker.sv
// Port-level checker for the SHA-1 stream hasher, bound to the top level.
module sha1sh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled digest word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled digest word changed");

   // Input is never taken while the digest is being delivered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready during digest output");

   // Last mark only on word four
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == 3'd4)))
      else $error("last mark and word index disagree");

   // Digest words follow each other in order
   a_word_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tuser == $past(rsp_tuser) + 3'd1))
      else $error("digest word sequence broken");

   // After the last word the block goes back to taking input
   a_back_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("block not idle after digest");

endmodule

bind sha1_stream_hasher_core sha1sh_checker u_sha1sh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
